@@ src/pjs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Parallel job scheduler package
// Widths, heap entry type, store request types and controller states.
// ----------------------------------------------------------------------------
package pjs_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int IDX_W       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
  localparam int CHILD_W     = IDX_W + 2;
  localparam int CFG_W       = 5;
  localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int DUR_W       = 32;
  localparam int TIME_W      = 63;
  localparam int WORKER_W    = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // One heap slot: the worker held there and its next free tick.
  typedef struct packed {
    logic [TIME_W-1:0] ftime;
    logic [IDX_W-1:0]  wnum;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             clear;
    logic             re;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } store_req_t;

  typedef struct packed {
    entry_t rd_a;
    entry_t rd_b;
  } store_rsp_t;

  typedef struct packed {
    logic              load;
    logic [IDX_W-1:0]  wnum;
    logic [TIME_W-1:0] start;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_LEVEL,
    ST_CMP
  } sched_state_e;

  // True if entry a is ordered before entry b by (free time, worker number).
  function automatic logic earlier(entry_t a, entry_t b);
    logic r;
    if (a.ftime != b.ftime) begin
      r = (a.ftime < b.ftime);
    end else begin
      r = (a.wnum < b.wnum);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/pjs_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, read data registered on read enable.
// ----------------------------------------------------------------------------
module pjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic                                          re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]                              rdata_a_o,
  output logic      [WIDTH-1:0]                              rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

@@ src/pjs_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Heap store
// Heap RAM with one valid bit per slot; an unwritten slot reads as its reset.
// ----------------------------------------------------------------------------
module pjs_store import pjs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire store_req_t req_i,
  output store_rsp_t      rsp_o
);

  logic [MAX_WORKERS-1:0] valid_q;
  logic                   va_q, vb_q;
  logic [IDX_W-1:0]       addr_a_q, addr_b_q;
  logic [ENTRY_W-1:0]     ram_a, ram_b;
  entry_t                 rst_a, rst_b;

  pjs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WORKERS)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (req_i.we),
    .waddr_i   (req_i.waddr),
    .wdata_i   (req_i.wdata),
    .re_i      (req_i.re),
    .raddr_a_i (req_i.raddr_a),
    .raddr_b_i (req_i.raddr_b),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clear) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  // Valid bits are sampled alongside the RAM read so they line up with its data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (req_i.re) begin
      va_q <= valid_q[req_i.raddr_a];
      vb_q <= valid_q[req_i.raddr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      addr_a_q <= req_i.raddr_a;
      addr_b_q <= req_i.raddr_b;
    end
  end

  always_comb begin
    rst_a.ftime = '0;
    rst_a.wnum  = addr_a_q;
    rst_b.ftime = '0;
    rst_b.wnum  = addr_b_q;
    rsp_o.rd_a  = va_q ? entry_t'(ram_a) : rst_a;
    rsp_o.rd_b  = vb_q ? entry_t'(ram_b) : rst_b;
  end

endmodule
`default_nettype wire

@@ src/pjs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler controller
// Takes the root, updates its free time and sifts it down level by level.
// ----------------------------------------------------------------------------
module pjs_ctrl import pjs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [DUR_W-1:0] duration_i,
  input  wire logic [CNT_W-1:0] active_i,
  input  wire logic             out_free_i,
  output res_t                  res_o,
  output store_req_t            req_o,
  input  wire store_rsp_t       rsp_i
);

  sched_state_e       state_q, state_d;
  logic [DUR_W-1:0]   dur_q, dur_d;
  entry_t             cur_q, cur_d;
  logic [IDX_W-1:0]   pos_q, pos_d;

  logic [CHILD_W-1:0] left, right, n_ext;
  logic               left_ok, right_ok;
  logic               a_lt_c, b_lt_c, b_lt_a;
  logic               take_left, take_right, go_down;
  logic [TIME_W:0]    sum;
  entry_t             upd;

  always_comb begin
    left     = (CHILD_W'(pos_q) << 1) + CHILD_W'(1);
    right    = left + CHILD_W'(1);
    n_ext    = CHILD_W'(active_i);
    left_ok  = (left < n_ext);
    right_ok = (right < n_ext);
    // The three compares run side by side; the winner is picked afterwards.
    a_lt_c     = earlier(rsp_i.rd_a, cur_q);
    b_lt_c     = earlier(rsp_i.rd_b, cur_q);
    b_lt_a     = earlier(rsp_i.rd_b, rsp_i.rd_a);
    take_right = right_ok && (a_lt_c ? b_lt_a : b_lt_c);
    take_left  = a_lt_c && !take_right;
    go_down    = take_left || take_right;
    sum        = {1'b0, rsp_i.rd_a.ftime} + (TIME_W+1)'(dur_q);
    upd.wnum   = rsp_i.rd_a.wnum;
    upd.ftime  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (out_free_i) state_d = ST_LEVEL;
      end
      ST_LEVEL: begin
        state_d = left_ok ? ST_CMP : ST_IDLE;
      end
      ST_CMP: begin
        state_d = go_down ? ST_LEVEL : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    res_o      = '0;
    req_o      = '0;
    dur_d      = dur_q;
    cur_d      = cur_q;
    pos_d      = pos_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        req_o.re      = in_valid_i;
        req_o.raddr_a = '0;
        req_o.raddr_b = '0;
        dur_d         = duration_i;
      end
      ST_ROOT: begin
        res_o.load  = out_free_i;
        res_o.wnum  = rsp_i.rd_a.wnum;
        res_o.start = rsp_i.rd_a.ftime;
        cur_d       = upd;
        pos_d       = '0;
      end
      ST_LEVEL: begin
        if (left_ok) begin
          req_o.re      = 1'b1;
          req_o.raddr_a = left[IDX_W-1:0];
          req_o.raddr_b = right[IDX_W-1:0];
        end else begin
          req_o.we    = 1'b1;
          req_o.waddr = pos_q;
          req_o.wdata = cur_q;
        end
      end
      ST_CMP: begin
        req_o.we    = 1'b1;
        req_o.waddr = pos_q;
        if (take_right) begin
          req_o.wdata = rsp_i.rd_b;
          pos_d       = right[IDX_W-1:0];
        end else if (take_left) begin
          req_o.wdata = rsp_i.rd_a;
          pos_d       = left[IDX_W-1:0];
        end else begin
          req_o.wdata = cur_q;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dur_q <= dur_d;
    cur_q <= cur_d;
    pos_q <= pos_d;
  end

endmodule
`default_nettype wire

@@ src/parallel_job_scheduler_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Parallel job scheduler: on acceptance the heap root is read, and the result is
// loaded into the output register once that register is free. The item then
// sifts down until it reaches a leaf or a compare stops it, descending at most
// floor(log2 n) heap levels; each level costs one RAM read and one compare/write.
// A new input is taken only once the sift of the last one is done.
// Reset is asynchronous and immediate: valid bits clear, worker count is one.
// ----------------------------------------------------------------------------
module parallel_job_scheduler_unit import pjs_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [DUR_W-1:0]    duration_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [WORKER_W-1:0] worker_o,
  output logic      [TIME_W-1:0]   start_time_o
);

  // The worker count register. Writing it also clears the store's valid
  // bits, so every slot reads back as free time zero and worker number equal
  // to its heap position, which is the cleared schedule.
  logic [CFG_W-1:0]  wcount_q;
  logic [CNT_W-1:0]  active;
  logic [CMP_W-1:0]  wc_ext;

  store_req_t        ctrl_req, store_req;
  store_rsp_t        store_rsp;
  res_t              res;

  logic              out_valid_q;
  logic [WORKER_W-1:0] worker_q;
  logic [TIME_W-1:0] start_q;
  logic              out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcount_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      wcount_q <= cfg_wdata_i;
    end
  end

  // A count of zero behaves as one worker, and a count above the store depth
  // is held at the depth.
  always_comb begin
    wc_ext = CMP_W'(wcount_q);
    if (wc_ext == '0) begin
      active = CNT_W'(1);
    end else if (wc_ext > CMP_W'(MAX_WORKERS)) begin
      active = CNT_W'(MAX_WORKERS);
    end else begin
      active = CNT_W'(wc_ext);
    end
  end

  always_comb begin
    store_req       = ctrl_req;
    store_req.clear = cfg_we_i;
  end

  pjs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .duration_i (duration_i),
    .active_i   (active),
    .out_free_i (out_free),
    .res_o      (res),
    .req_o      (ctrl_req),
    .rsp_i      (store_rsp)
  );

  pjs_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (store_req),
    .rsp_o  (store_rsp)
  );

  // Output register. It parts the two sides: the controller may take the next
  // transaction while a result still waits here, and only holds at the root
  // read if the register is still full when the next result is ready.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      worker_q <= WORKER_W'(res.wnum);
      start_q  <= res.start;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign worker_o     = worker_q;
  assign start_time_o = start_q;

  // A result is only loaded into a register that is empty or being emptied.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending output");

  // The root of the heap always names a worker in use.
  a_worker_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.load |-> (CMP_W'(res.wnum) < CMP_W'(active)))
    else $error("scheduled worker outside the active range");

  // The controller never reads and writes the store in the same cycle.
  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_req.we |-> !ctrl_req.re)
    else $error("store read and write collide");

  // One transaction at a time: acceptance is followed by a busy cycle.
  a_one_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a job is in flight");

endmodule
`default_nettype wire
